// ----- src/rgbled_pkg.sv -----
// Shared codes, widths and the gamma table generator for the RGB LED HSV gamma controller.
package rgbled_pkg;

    localparam int LEVEL_W = 17;
    localparam int HUE_W   = 16;
    localparam int OUT_PWM_W = 16;

    localparam logic [LEVEL_W-1:0] ONE_Q16 = 17'h10000;

    typedef logic [LEVEL_W-1:0] level_t;
    typedef logic [2:0]         channel_t;

    localparam logic ACT_WRITE = 1'b0;
    localparam logic ACT_READ  = 1'b1;

    localparam channel_t CH_RED   = 3'd0;
    localparam channel_t CH_GREEN = 3'd1;
    localparam channel_t CH_BLUE  = 3'd2;
    localparam channel_t CH_HUE   = 3'd3;
    localparam channel_t CH_SAT   = 3'd4;
    localparam channel_t CH_VALUE = 3'd5;

    // Operations run on the shared multiplier, in the order they are issued.
    typedef logic [2:0] op_t;
    localparam op_t OP_SF = 3'd0;   // s * f
    localparam op_t OP_SG = 3'd1;   // s * (1 - f)
    localparam op_t OP_P  = 3'd2;   // v * (1 - s)
    localparam op_t OP_Q  = 3'd3;   // v * (1 - s*f)
    localparam op_t OP_T  = 3'd4;   // v * (1 - s*(1-f))
    localparam op_t OP_GR = 3'd5;   // red gamma index
    localparam op_t OP_GG = 3'd6;   // green gamma index
    localparam op_t OP_GB = 3'd7;   // blue gamma index

    // Exact gamma 2.2 entry: the largest R in [0, m] with R == 0 or
    // (2R-1)^5 * n^11 <= i^11 * (2m)^5. Evaluated only at elaboration.
    function automatic logic [OUT_PWM_W-1:0] gamma_entry(int unsigned i, int unsigned n,
                                                         int unsigned m);
        logic [255:0] rhs;
        logic [255:0] lhs;
        int unsigned lo;
        int unsigned hi;
        int unsigned mid;
        rhs = 256'd1;
        for (int k = 0; k < 11; k++) begin
            rhs = rhs * 256'(i);
        end
        for (int k = 0; k < 5; k++) begin
            rhs = rhs * 256'(2 * m);
        end
        lo = 0;
        hi = m;
        while (lo < hi) begin
            mid = (lo + hi + 1) >> 1;
            lhs = 256'd1;
            for (int k = 0; k < 5; k++) begin
                lhs = lhs * 256'(2 * mid - 1);
            end
            for (int k = 0; k < 11; k++) begin
                lhs = lhs * 256'(n);
            end
            if (lhs <= rhs) begin
                lo = mid;
            end else begin
                hi = mid - 1;
            end
        end
        return OUT_PWM_W'(lo);
    endfunction

endpackage

// ----- src/rgb_led_hsv_gamma_controller_core.sv -----
// Top level of the RGB LED controller: HSV conversion and gamma-corrected PWM compare values.
//
// Usage. Each input word on the s_ channel is one channel access: s_tuser carries the
// action (write or read) and the channel, s_tdata carries the Q1.16 write level.
// Every accepted word yields exactly one output word on the m_ channel holding the
// read data (zero for writes) and the three current PWM compare values.
//
// Timing. All products go through one shared bit-serial 17 x 17 multiplier that
// consumes one multiplier bit per cycle; each product is a load, 17 shift-add
// steps and a store. A read or an invalid-channel write goes straight to the done
// state. A red, green or blue write runs the three gamma index products. A hue,
// saturation or value write with nonzero saturation also runs the five HSV
// products first; with zero saturation it runs only the three gamma products.
// One word is processed at a time; s_tready is high whenever the core is idle,
// even while a finished word still waits in the output register.
//
// Reset. aresetn is synchronous and active low; it clears all levels, the hue and
// the compare values to zero and empties the output register.
//
// Stalls. When the receiver holds m_tready low, the finished word waits in the
// output register; a following word may be accepted and processed, but its result
// is held back until the output register has been emptied.
module rgb_led_hsv_gamma_controller_core #(
    parameter int PWM_BITS     = 16,
    parameter int GAMMA_LEVELS = 256
) (
    input  logic        aclk,
    input  logic        aresetn,
    // s_tdata: [16:0] level_in, [23:17] zero
    input  logic [23:0] s_tdata,
    // s_tuser: [0] action, [3:1] channel
    input  logic [3:0]  s_tuser,
    input  logic        s_tvalid,
    output logic        s_tready,
    // m_tdata: [16:0] read_data, [32:17] pwm_red, [48:33] pwm_green,
    //          [64:49] pwm_blue, [71:65] zero
    output logic [71:0] m_tdata,
    output logic        m_tvalid,
    input  logic        m_tready
);
    import rgbled_pkg::*;

    localparam int IDX_W = $clog2(GAMMA_LEVELS);
    localparam logic [LEVEL_W-1:0] GAMMA_MAX = LEVEL_W'(GAMMA_LEVELS - 1);
    localparam int unsigned PWM_MAX = (32'd1 << PWM_BITS) - 32'd1;
    localparam int PAYLOAD_W = LEVEL_W + 3 * OUT_PWM_W;

    localparam logic [2:0] ST_IDLE  = 3'd0;
    localparam logic [2:0] ST_LOAD  = 3'd1;
    localparam logic [2:0] ST_MUL   = 3'd2;
    localparam logic [2:0] ST_STORE = 3'd3;
    localparam logic [2:0] ST_DONE  = 3'd4;

    // Gamma table, built at elaboration.
    logic [PWM_BITS-1:0] gamma_rom [GAMMA_LEVELS];
    for (genvar gi = 0; gi < GAMMA_LEVELS; gi++) begin : g_gamma
        localparam logic [OUT_PWM_W-1:0] ENTRY =
            gamma_entry(gi, GAMMA_LEVELS - 1, PWM_MAX);
        assign gamma_rom[gi] = ENTRY[PWM_BITS-1:0];
    end

    logic [2:0]           state_reg, state_next;
    op_t                  op_reg, op_next;
    logic [4:0]           bit_cnt_reg, bit_cnt_next;
    level_t               mcand_reg, mcand_next;
    logic [2*LEVEL_W-1:0] prod_reg, prod_next;

    level_t               red_level_reg, red_level_next;
    level_t               green_level_reg, green_level_next;
    level_t               blue_level_reg, blue_level_next;
    level_t               sat_level_reg, sat_level_next;
    level_t               val_level_reg, val_level_next;
    logic [HUE_W-1:0]     hue_level_reg, hue_level_next;

    level_t               sf_reg, sf_next;
    level_t               sg_reg, sg_next;
    level_t               p_reg, p_next;
    level_t               q_reg, q_next;

    logic [PWM_BITS-1:0]  pwm_red_reg, pwm_red_next;
    logic [PWM_BITS-1:0]  pwm_green_reg, pwm_green_next;
    logic [PWM_BITS-1:0]  pwm_blue_reg, pwm_blue_next;

    level_t               rd_reg, rd_next;
    logic                 m_valid_reg, m_valid_next;
    logic [PAYLOAD_W-1:0] m_data_reg, m_data_next;

    logic                 in_fire;
    logic                 in_action;
    channel_t             in_channel;
    level_t               in_level;
    level_t               s_eff;
    level_t               v_eff;
    logic [HUE_W+2:0]     hue_scaled;
    logic [2:0]           sector;
    logic [HUE_W-1:0]     frac;
    logic [LEVEL_W:0]     step_sum;
    level_t               mul_result;
    logic [IDX_W-1:0]     gamma_idx;
    level_t               load_a;
    level_t               load_b;
    logic                 out_free;

    assign s_tready   = (state_reg == ST_IDLE);
    assign in_fire    = s_tvalid && s_tready;
    assign in_action  = s_tuser[0];
    assign in_channel = s_tuser[3:1];
    // Levels above 1.0 saturate.
    assign in_level   = (s_tdata[LEVEL_W-1:0] > ONE_Q16) ? ONE_Q16 : s_tdata[LEVEL_W-1:0];

    assign s_eff = (in_channel == CH_SAT) ? in_level : sat_level_reg;
    assign v_eff = (in_channel == CH_VALUE) ? in_level : val_level_reg;

    // hue / 60 in Q16 is the hue level times six; the hue is always below one turn.
    assign hue_scaled = (HUE_W+3)'({hue_level_reg, 2'b00}) + (HUE_W+3)'({hue_level_reg, 1'b0});
    assign sector     = hue_scaled[HUE_W+2:HUE_W];
    assign frac       = hue_scaled[HUE_W-1:0];

    // One shift-add step of the LSB-first serial multiplier.
    assign step_sum   = {1'b0, prod_reg[2*LEVEL_W-1:LEVEL_W]}
                      + (prod_reg[0] ? {1'b0, mcand_reg} : {(LEVEL_W+1){1'b0}});
    assign mul_result = prod_reg[2*LEVEL_W-2:16];
    assign gamma_idx  = prod_reg[16+IDX_W-1:16];

    assign out_free   = !m_valid_reg || m_tready;

    always_comb begin
        load_a = val_level_reg;
        load_b = GAMMA_MAX;
        case (op_reg)
            OP_SF: begin
                load_a = sat_level_reg;
                load_b = {1'b0, frac};
            end
            OP_SG: begin
                load_a = sat_level_reg;
                load_b = ONE_Q16 - {1'b0, frac};
            end
            OP_P: begin
                load_a = val_level_reg;
                load_b = ONE_Q16 - sat_level_reg;
            end
            OP_Q: begin
                load_a = val_level_reg;
                load_b = ONE_Q16 - sf_reg;
            end
            OP_T: begin
                load_a = val_level_reg;
                load_b = ONE_Q16 - sg_reg;
            end
            OP_GR: begin
                load_a = red_level_reg;
                load_b = GAMMA_MAX;
            end
            OP_GG: begin
                load_a = green_level_reg;
                load_b = GAMMA_MAX;
            end
            default: begin
                load_a = blue_level_reg;
                load_b = GAMMA_MAX;
            end
        endcase
    end

    always_comb begin
        state_next       = state_reg;
        op_next          = op_reg;
        bit_cnt_next     = bit_cnt_reg;
        mcand_next       = mcand_reg;
        prod_next        = prod_reg;
        red_level_next   = red_level_reg;
        green_level_next = green_level_reg;
        blue_level_next  = blue_level_reg;
        sat_level_next   = sat_level_reg;
        val_level_next   = val_level_reg;
        hue_level_next   = hue_level_reg;
        sf_next          = sf_reg;
        sg_next          = sg_reg;
        p_next           = p_reg;
        q_next           = q_reg;
        pwm_red_next     = pwm_red_reg;
        pwm_green_next   = pwm_green_reg;
        pwm_blue_next    = pwm_blue_reg;
        rd_next          = rd_reg;
        m_valid_next     = m_valid_reg && !m_tready;
        m_data_next      = m_data_reg;

        case (state_reg)
            ST_IDLE: begin
                if (in_fire) begin
                    rd_next    = '0;
                    state_next = ST_DONE;
                    if (in_action == ACT_READ) begin
                        case (in_channel)
                            CH_RED:   rd_next = red_level_reg;
                            CH_GREEN: rd_next = green_level_reg;
                            CH_BLUE:  rd_next = blue_level_reg;
                            CH_HUE:   rd_next = {1'b0, hue_level_reg};
                            CH_SAT:   rd_next = sat_level_reg;
                            CH_VALUE: rd_next = val_level_reg;
                            default:  rd_next = '0;
                        endcase
                    end else begin
                        case (in_channel)
                            CH_RED: begin
                                red_level_next = in_level;
                                op_next        = OP_GR;
                                state_next     = ST_LOAD;
                            end
                            CH_GREEN: begin
                                green_level_next = in_level;
                                op_next          = OP_GR;
                                state_next       = ST_LOAD;
                            end
                            CH_BLUE: begin
                                blue_level_next = in_level;
                                op_next         = OP_GR;
                                state_next      = ST_LOAD;
                            end
                            CH_HUE, CH_SAT, CH_VALUE: begin
                                if (in_channel == CH_HUE) begin
                                    // A full turn wraps to zero.
                                    hue_level_next = (in_level == ONE_Q16) ?
                                                     '0 : in_level[HUE_W-1:0];
                                end
                                sat_level_next = s_eff;
                                val_level_next = v_eff;
                                state_next     = ST_LOAD;
                                if (s_eff == '0) begin
                                    red_level_next   = v_eff;
                                    green_level_next = v_eff;
                                    blue_level_next  = v_eff;
                                    op_next          = OP_GR;
                                end else begin
                                    op_next = OP_SF;
                                end
                            end
                            default: begin
                                state_next = ST_DONE;
                            end
                        endcase
                    end
                end
            end
            ST_LOAD: begin
                mcand_next   = load_a;
                prod_next    = {{LEVEL_W{1'b0}}, load_b};
                bit_cnt_next = '0;
                state_next   = ST_MUL;
            end
            ST_MUL: begin
                prod_next    = {step_sum, prod_reg[LEVEL_W-1:1]};
                bit_cnt_next = bit_cnt_reg + 5'd1;
                if (bit_cnt_reg == 5'(LEVEL_W - 1)) begin
                    state_next = ST_STORE;
                end
            end
            ST_STORE: begin
                state_next = ST_LOAD;
                op_next    = op_reg + 3'd1;
                case (op_reg)
                    OP_SF: sf_next = mul_result;
                    OP_SG: sg_next = mul_result;
                    OP_P:  p_next  = mul_result;
                    OP_Q:  q_next  = mul_result;
                    OP_T: begin
                        // mul_result is t here.
                        case (sector)
                            3'd0: begin
                                red_level_next   = val_level_reg;
                                green_level_next = mul_result;
                                blue_level_next  = p_reg;
                            end
                            3'd1: begin
                                red_level_next   = q_reg;
                                green_level_next = val_level_reg;
                                blue_level_next  = p_reg;
                            end
                            3'd2: begin
                                red_level_next   = p_reg;
                                green_level_next = val_level_reg;
                                blue_level_next  = mul_result;
                            end
                            3'd3: begin
                                red_level_next   = p_reg;
                                green_level_next = q_reg;
                                blue_level_next  = val_level_reg;
                            end
                            3'd4: begin
                                red_level_next   = mul_result;
                                green_level_next = p_reg;
                                blue_level_next  = val_level_reg;
                            end
                            default: begin
                                red_level_next   = val_level_reg;
                                green_level_next = p_reg;
                                blue_level_next  = q_reg;
                            end
                        endcase
                    end
                    OP_GR: pwm_red_next   = gamma_rom[gamma_idx];
                    OP_GG: pwm_green_next = gamma_rom[gamma_idx];
                    default: begin
                        pwm_blue_next = gamma_rom[gamma_idx];
                        state_next    = ST_DONE;
                    end
                endcase
            end
            ST_DONE: begin
                if (out_free) begin
                    m_valid_next = 1'b1;
                    m_data_next  = {OUT_PWM_W'(pwm_blue_reg), OUT_PWM_W'(pwm_green_reg),
                                    OUT_PWM_W'(pwm_red_reg), rd_reg};
                    state_next   = ST_IDLE;
                end
            end
            default: begin
                state_next = ST_IDLE;
            end
        endcase
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            state_reg       <= ST_IDLE;
            op_reg          <= OP_SF;
            bit_cnt_reg     <= '0;
            red_level_reg   <= '0;
            green_level_reg <= '0;
            blue_level_reg  <= '0;
            sat_level_reg   <= '0;
            val_level_reg   <= '0;
            hue_level_reg   <= '0;
            pwm_red_reg     <= '0;
            pwm_green_reg   <= '0;
            pwm_blue_reg    <= '0;
            m_valid_reg     <= 1'b0;
        end else begin
            state_reg       <= state_next;
            op_reg          <= op_next;
            bit_cnt_reg     <= bit_cnt_next;
            red_level_reg   <= red_level_next;
            green_level_reg <= green_level_next;
            blue_level_reg  <= blue_level_next;
            sat_level_reg   <= sat_level_next;
            val_level_reg   <= val_level_next;
            hue_level_reg   <= hue_level_next;
            pwm_red_reg     <= pwm_red_next;
            pwm_green_reg   <= pwm_green_next;
            pwm_blue_reg    <= pwm_blue_next;
            m_valid_reg     <= m_valid_next;
        end
        mcand_reg  <= mcand_next;
        prod_reg   <= prod_next;
        sf_reg     <= sf_next;
        sg_reg     <= sg_next;
        p_reg      <= p_next;
        q_reg      <= q_next;
        rd_reg     <= rd_next;
        m_data_reg <= m_data_next;
    end

    assign m_tvalid = m_valid_reg;
    assign m_tdata  = {(72 - PAYLOAD_W)'(0), m_data_reg};

    // An accepted word always starts work; the core never stays idle on it.
    a_accept_starts: assert property (@(posedge aclk) disable iff (!aresetn)
        in_fire |=> state_reg != ST_IDLE)
        else $error("accepted word did not start processing");

    // All stored levels stay within 1.0.
    a_levels_in_range: assert property (@(posedge aclk) disable iff (!aresetn)
        red_level_reg <= ONE_Q16 && green_level_reg <= ONE_Q16 &&
        blue_level_reg <= ONE_Q16 && sat_level_reg <= ONE_Q16 &&
        val_level_reg <= ONE_Q16)
        else $error("stored level above 1.0");

    // A finished word with a free output register is presented next cycle.
    a_done_presents: assert property (@(posedge aclk) disable iff (!aresetn)
        (state_reg == ST_DONE && out_free) |=> (m_tvalid && state_reg == ST_IDLE))
        else $error("finished word was not presented");

    // The serial multiplier never runs past its last multiplier bit.
    a_mul_count: assert property (@(posedge aclk) disable iff (!aresetn)
        state_reg == ST_MUL |-> bit_cnt_reg < 5'(LEVEL_W))
        else $error("multiplier step count overrun");

endmodule
